### rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Depth of the command queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One command: every result caused by one accepted character.
  typedef struct packed {
    logic [2:0][7:0] bytes;    // result bytes in output order
    logic [1:0]      last;     // index of the final result of this command
    logic            is_byte;  // results carry decoded bytes
    logic            err;      // decode error flag for every result
    logic            done;     // final result closes the text
  } cmd_t;

endpackage

### rtl/core/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them to sextets, assembles groups and turns each
// character that completes a group or ends the text into one command.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_char,
  input  logic              end_of_text,
  output logic              cmd_push,
  output b64d_pkg::cmd_t    cmd
);

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } char_map_t;

  function automatic char_map_t map_char(input logic [7:0] c);
    char_map_t m;
    m.ok  = 1'b1;
    m.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      m.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      m.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      m.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      m.val = 6'd62;
    end else if (c == 8'h2F) begin
      m.val = 6'd63;
    end else if (c != b64d_pkg::PAD_CHAR) begin
      m.ok = 1'b0;
    end
    return m;
  endfunction

  logic [1:0]  pos, pos_next;
  logic [17:0] held, held_next;
  logic        inv, inv_next;
  logic        pad3, pad3_next;
  logic        halted, halted_next;

  char_map_t   cm;
  logic        is_pad;
  logic [7:0]  b0, b1, b2;

  assign cm     = map_char(text_char);
  assign is_pad = (text_char == b64d_pkg::PAD_CHAR);
  assign b0     = {held[17:12], held[11:10]};
  assign b1     = {held[9:6], held[5:2]};
  assign b2     = {held[1:0], cm.val};

  always_comb begin
    pos_next    = pos;
    held_next   = held;
    inv_next    = inv;
    pad3_next   = pad3;
    halted_next = halted;
    cmd_push    = 1'b0;
    cmd         = '0;

    if (accept) begin
      if (!halted) begin
        if (pos != 2'd3) begin
          if (!cm.ok) begin
            inv_next = 1'b1;
          end
          if (pos == 2'd2) begin
            pad3_next = is_pad;
          end
          held_next = {held[11:0], cm.val};
          pos_next  = pos + 2'd1;
        end else begin
          cmd_push = 1'b1;
          if (inv || !cm.ok) begin
            cmd.err     = 1'b1;
            halted_next = 1'b1;
          end else begin
            // Compact the bytes: skip the second one after a padded third char.
            cmd.is_byte  = 1'b1;
            cmd.bytes[0] = b0;
            cmd.bytes[1] = pad3 ? b2 : b1;
            cmd.bytes[2] = b2;
            if (pad3) begin
              cmd.last = is_pad ? 2'd0 : 2'd1;
            end else begin
              cmd.last = is_pad ? 2'd1 : 2'd2;
            end
          end
          pos_next  = 2'd0;
          held_next = '0;
          inv_next  = 1'b0;
          pad3_next = 1'b0;
        end
      end

      if (end_of_text) begin
        if (!cmd_push) begin
          // End marker carries the halt status of the text.
          cmd_push = 1'b1;
          cmd.err  = halted;
        end
        cmd.done    = 1'b1;
        pos_next    = 2'd0;
        held_next   = '0;
        inv_next    = 1'b0;
        pad3_next   = 1'b0;
        halted_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= 2'd0;
      held   <= '0;
      inv    <= 1'b0;
      pad3   <= 1'b0;
      halted <= 1'b0;
    end else begin
      pos    <= pos_next;
      held   <= held_next;
      inv    <= inv_next;
      pad3   <= pad3_next;
      halted <= halted_next;
    end
  end

`ifndef SYNTHESIS
  a_halt_holds_empty_group: assert property (@(posedge clk) disable iff (rst)
    halted |-> (pos == 2'd0 && !inv))
    else $error("halted with a partial group held");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (!halted && pos == 2'd0))
    else $error("end of text did not clear decoder state");
`endif

endmodule

### rtl/core/b64d_cmdq.sv
// ----------------------------------------------------------------------------
// b64d_cmdq
// Short register queue of commands between the front and the back part.
// ----------------------------------------------------------------------------
module b64d_cmdq #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output b64d_pkg::cmd_t dout,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr, wr_ptr_next;
  logic [PW-1:0]  rd_ptr, rd_ptr_next;
  logic [CW-1:0]  count, count_next;
  logic           do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count out of range");
`endif

endmodule

### rtl/core/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Expands the command at the queue head into its results, one per pop.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic           clk,
  input  logic           rst,
  input  b64d_pkg::cmd_t head,
  input  logic           head_empty,
  output logic           head_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     byte_value,
  output logic           byte_valid,
  output logic           run_last,
  output logic           text_done,
  output logic           decode_error
);

  logic [1:0] idx, idx_next;
  logic       at_last;

  assign at_last      = (idx == head.last);
  assign empty        = head_empty;
  assign byte_value   = head.bytes[idx];
  assign byte_valid   = head.is_byte;
  assign run_last     = at_last;
  assign text_done    = head.done && at_last;
  assign decode_error = head.err;

  always_comb begin
    head_pop = 1'b0;
    idx_next = idx;
    if (pop && !head_empty) begin
      if (at_last) begin
        head_pop = 1'b1;
        idx_next = 2'd0;
      end else begin
        idx_next = idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else begin
      idx <= idx_next;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !head_empty |-> (idx <= head.last))
    else $error("result index past end of command");
`endif

endmodule

### rtl/core/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: characters in, decoded bytes and markers out.
// ----------------------------------------------------------------------------
// One character is taken per cycle while full is low. Each character gives
// zero to three results; the first can be popped on the cycle after the
// character is taken, and the back part hands out one result per cycle
// while pop is high, so a complete unpadded group gives three bytes. full
// rises when the QUEUE_DEPTH-entry command queue between the front and the
// back part is full: when the result side stalls, or when a character that
// completes a group is closely followed by characters that give results of
// their own, since the back part frees a command only after its last result.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_value,
  output logic       byte_valid,
  output logic       run_last,
  output logic       text_done,
  output logic       decode_error
);

  b64d_pkg::cmd_t cmd, head;
  logic           cmd_push, q_full, q_empty, head_pop;

  assign full = q_full;

  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (push && !q_full),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  b64d_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd),
    .full  (q_full),
    .pop   (head_pop),
    .dout  (head),
    .empty (q_empty)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_empty   (q_empty),
    .head_pop     (head_pop),
    .pop          (pop),
    .empty        (empty),
    .byte_value   (byte_value),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .text_done    (text_done),
    .decode_error (decode_error)
  );

endmodule

### bench/b64d_result_checker.sv
// ----------------------------------------------------------------------------
// b64d_result_checker
// Watches both queue interfaces of the base64 stream decoder, predicts every
// result from the accepted characters and compares each popped result field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module b64d_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] byte_value,
  input  logic       byte_valid,
  input  logic       run_last,
  input  logic       text_done,
  input  logic       decode_error,
  output int         fail_count,
  output int         pending_results
);

  typedef struct {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;
    logic       decode_error;
  } decoded_result_t;

  decoded_result_t expected_results[$];

  // Decoder state as the predictor sees it.
  logic [1:0]  group_position;
  logic [17:0] held_sextets;
  logic        group_invalid;
  logic        third_was_pad;
  logic        halted;

  function automatic logic char_sextet(input logic [7:0] c, output logic [5:0] v);
    v = '0;
    if (c >= "A" && c <= "Z") begin
      v = 6'(c - "A");
      return 1'b1;
    end
    if (c >= "a" && c <= "z") begin
      v = 6'(c - "a" + 26);
      return 1'b1;
    end
    if (c >= "0" && c <= "9") begin
      v = 6'(c - "0" + 52);
      return 1'b1;
    end
    if (c == "+") begin
      v = 6'd62;
      return 1'b1;
    end
    if (c == "/") begin
      v = 6'd63;
      return 1'b1;
    end
    return c == b64d_pkg::PAD_CHAR;
  endfunction

  function automatic decoded_result_t make_result(input logic [7:0] b, input logic valid,
                                                  input logic err);
    decoded_result_t r;
    r.byte_value   = b;
    r.byte_valid   = valid;
    r.run_last     = 1'b0;
    r.text_done    = 1'b0;
    r.decode_error = err;
    return r;
  endfunction

  task automatic clear_group();
    group_position = '0;
    held_sextets   = '0;
    group_invalid  = 1'b0;
    third_was_pad  = 1'b0;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic eot);
    decoded_result_t batch [3];
    int              n;
    logic [5:0]      v;
    logic            ok;
    logic [5:0]      v1, v2, v3;
    n = 0;
    if (!halted) begin
      ok = char_sextet(c, v);
      if (group_position != 2'd3) begin
        if (!ok) group_invalid = 1'b1;
        if (group_position == 2'd2) third_was_pad = (c == b64d_pkg::PAD_CHAR);
        held_sextets   = {held_sextets[11:0], v};
        group_position = group_position + 2'd1;
      end else begin
        if (group_invalid || !ok) begin
          batch[n] = make_result(8'h00, 1'b0, 1'b1);
          n++;
          halted = 1'b1;
        end else begin
          {v1, v2, v3} = held_sextets;
          batch[n] = make_result({v1, v2[5:4]}, 1'b1, 1'b0);
          n++;
          // pad in third or fourth place drops its byte, each on its own
          if (!third_was_pad) begin
            batch[n] = make_result({v2[3:0], v3[5:2]}, 1'b1, 1'b0);
            n++;
          end
          if (c != b64d_pkg::PAD_CHAR) begin
            batch[n] = make_result({v3[1:0], v}, 1'b1, 1'b0);
            n++;
          end
        end
        clear_group();
      end
    end
    if (eot) begin
      // close the text with a marker when the last character gave nothing
      if (n == 0) begin
        batch[n] = make_result(8'h00, 1'b0, halted);
        n++;
      end
      batch[n-1].text_done = 1'b1;
      clear_group();
      halted = 1'b0;
    end
    if (n > 0) batch[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(batch[i]);
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (fail_count < 40)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    decoded_result_t want;
    if (rst) begin
      expected_results.delete();
      clear_group();
      halted = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", byte_value, 0);
        end else begin
          want = expected_results.pop_front();
          if (byte_value !== want.byte_value)
            report_mismatch("byte_value", byte_value, want.byte_value);
          if (byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", byte_valid, want.byte_valid);
          if (run_last !== want.run_last)
            report_mismatch("run_last", run_last, want.run_last);
          if (text_done !== want.text_done)
            report_mismatch("text_done", text_done, want.text_done);
          if (decode_error !== want.decode_error)
            report_mismatch("decode_error", decode_error, want.decode_error);
        end
      end
      if (push && !full) predict_char(text_char, end_of_text);
    end
    pending_results = expected_results.size();
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the base64 stream decoder: directed texts for the
// padding, error and end-of-text cases, then random texts, mostly well formed,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

  logic       clk;
  logic       rst         = 1'b1;
  logic       push        = 1'b0;
  logic       full;
  logic [7:0] text_char   = 8'h00;
  logic       end_of_text = 1'b0;
  logic       empty;
  logic       pop         = 1'b0;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       run_last;
  logic       text_done;
  logic       decode_error;

  int   fail_count;
  int   pending_results;
  int   items_sent  = 0;
  logic idle_enable = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  base64_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .text_char    (text_char),
    .end_of_text  (end_of_text),
    .empty        (empty),
    .pop          (pop),
    .byte_value   (byte_value),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .text_done    (text_done),
    .decode_error (decode_error)
  );

  b64d_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .text_char       (text_char),
    .end_of_text     (end_of_text),
    .empty           (empty),
    .pop             (pop),
    .byte_value      (byte_value),
    .byte_valid      (byte_valid),
    .run_last        (run_last),
    .text_done       (text_done),
    .decode_error    (decode_error),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side: stall now and then while idling is enabled.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (idle_enable) begin
      pop <= ($urandom_range(99) >= 9);
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    if (idle_enable && $urandom_range(99) < 9) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    push        <= 1'b1;
    text_char   <= ch;
    end_of_text <= last;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && (i == s.len() - 1));
  endtask

  // Hold off requests until every predicted result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] text_buf [0:15];
    int         len;
    int         r;
    int         text_idx;
    repeat (5) @(posedge clk);
    rst         <= 1'b0;
    idle_enable <= 1'b1;
    @(posedge clk);

    send_text("az=9", 1'b0);   // pad in third place only
    send_text("AAAA", 1'b0);
    send_text("////", 1'b0);
    send_text("TQ==", 1'b1);   // byte result closes the text
    send_char(8'h80, 1'b0);    // invalid, error comes on the fourth
    send_text("+0A", 1'b0);
    send_char("B", 1'b0);      // ignored while halted
    send_char(8'hFF, 1'b1);    // marker carries the error
    send_text("Q*", 1'b1);     // invalid in a dropped partial group
    wait_drained();

    items_sent = 0;
    text_idx   = 0;
    while (items_sent < 250) begin
      idle_enable <= !(items_sent >= 90 && items_sent < 160);
      if (text_idx == 12) wait_drained();
      if ($urandom_range(99) < 70) begin
        len = 4 * $urandom_range(1, 4);
        for (int i = 0; i < len; i++) text_buf[i] = sextet_char(6'($urandom_range(63)));
        r = $urandom_range(2);
        if (r > 0) text_buf[len-1] = b64d_pkg::PAD_CHAR;
        if (r > 1) text_buf[len-2] = b64d_pkg::PAD_CHAR;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(99);
          if (r < 55) text_buf[i] = sextet_char(6'($urandom_range(63)));
          else if (r < 70) text_buf[i] = b64d_pkg::PAD_CHAR;
          else text_buf[i] = 8'($urandom_range(255));
        end
      end
      for (int i = 0; i < len; i++) send_char(text_buf[i], i == len - 1);
      text_idx++;
    end

    wait_drained();
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("base64_stream_decoder verification clean");
    end else begin
      $display("base64_stream_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("base64_stream_decoder verification failed");
    $finish;
  end

endmodule

### base64_stream_decoder.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_cmdq.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder.sv
bench/b64d_result_checker.sv
bench/tb_top.sv
